// File: design/chm_pkg.sv
// Shared types and constants for the chained hash map.
// No dependencies.
package chm_pkg;

    localparam int MAX_BUCKETS_DEF = 1024;
    localparam int MAX_ENTRIES_DEF = 4096;

    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 64;
    localparam int NBC_W     = 11;
    localparam int STATUS_W  = 3;
    localparam int ECNT_W    = 13;
    localparam int BTOT_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int MULT_W    = 32;
    localparam int LIMIT_W   = 8;

    localparam int RESET_INIT_BUCKETS = 10;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_GET     = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_REBUILD = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] value;
        logic             keep;
        logic             sat;
        logic [NBC_W-1:0] nbc;
    } item_t;

endpackage

// File: design/chm_hash.sv
// Universal hash unit: (a*key + b) mod p (mod-p skipped when p is zero), then mod bucket count.
// Shared 32x32 multiplier and a one-bit-per-cycle remainder loop. Uses chm_pkg.
module chm_hash
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    localparam int BIW = $clog2(MAX_BUCKETS),
    localparam int BCW = $clog2(MAX_BUCKETS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  key,
    input  logic [MULT_W-1:0] mult,
    input  logic [MULT_W-1:0] add,
    input  logic [KEY_W-1:0]  prime,
    input  logic [BCW-1:0]    len,
    output logic              done,
    output logic [BIW-1:0]    bucket
);

    typedef enum logic [2:0] {H_IDLE, H_MLO, H_MHI, H_SUM, H_MODP, H_MODL} hstate_t;

    hstate_t           state_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  acc_reg;
    logic [KEY_W-1:0]  div_reg;
    logic [KEY_W-1:0]  rem_reg;
    logic [MULT_W-1:0] hi_reg;
    logic [BCW-1:0]    len_reg;
    logic [5:0]        cnt_reg;
    logic              done_reg;
    logic [BIW-1:0]    bucket_reg;

    logic [MULT_W-1:0] mul_src;
    logic [KEY_W-1:0]  mul_p;
    logic [KEY_W:0]    trial;
    logic [KEY_W:0]    diff;
    logic [KEY_W-1:0]  rem_next;
    logic [KEY_W-1:0]  len_div;

    always_comb
    begin
        mul_src  = (state_reg == H_MLO) ? key_reg[31:0] : key_reg[63:32];
        mul_p    = mult * mul_src;
        trial    = {rem_reg, acc_reg[KEY_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_next = (trial >= {1'b0, div_reg}) ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
        len_div  = (len_reg == '0) ? 64'd1 : 64'(len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= H_IDLE;
            done_reg   <= 1'b0;
            key_reg    <= '0;
            acc_reg    <= '0;
            div_reg    <= '0;
            rem_reg    <= '0;
            hi_reg     <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            bucket_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        key_reg   <= key;
                        len_reg   <= len;
                        state_reg <= H_MLO;
                    end
                end
                H_MLO:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= H_MHI;
                end
                H_MHI:
                begin
                    hi_reg    <= mul_p[31:0];
                    acc_reg   <= acc_reg + {32'b0, add};
                    state_reg <= H_SUM;
                end
                H_SUM:
                begin
                    acc_reg <= acc_reg + {hi_reg, 32'b0};
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (prime != '0)
                    begin
                        div_reg   <= prime;
                        state_reg <= H_MODP;
                    end
                    else
                    begin
                        div_reg   <= len_div;
                        state_reg <= H_MODL;
                    end
                end
                H_MODP:
                begin
                    rem_reg <= rem_next;
                    acc_reg <= {acc_reg[KEY_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd63)
                    begin
                        acc_reg   <= rem_next;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        div_reg   <= len_div;
                        state_reg <= H_MODL;
                    end
                end
                H_MODL:
                begin
                    rem_reg <= rem_next;
                    acc_reg <= {acc_reg[KEY_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd63)
                    begin
                        bucket_reg <= rem_next[BIW-1:0];
                        done_reg   <= 1'b1;
                        state_reg  <= H_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

// File: design/chm_front.sv
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Uses chm_pkg.
module chm_front
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [KEY_W-1:0]  key,
    input  logic [KEY_W-1:0]  value,
    input  logic [NBC_W-1:0]  new_bucket_count,
    input  logic              hold,
    output item_t             q_item,
    output logic              q_valid,
    input  logic              q_take
);

    item_t      q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       accept;
    item_t      cls;

    always_comb
    begin
        cls.op    = op_t'(func);
        cls.key   = key;
        cls.value = value;
        cls.keep  = (new_bucket_count == '0);
        cls.sat   = (32'(new_bucket_count) > MAX_BUCKETS);
        cls.nbc   = new_bucket_count;
    end

    assign in_stall = (cnt_reg == 2'd2) || hold;
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_take && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, accept} - {1'b0, q_take && q_valid};
        end
    end

endmodule

// File: design/chm_back.sv
// Back end: chain walks, insert/remove, rebuilds and the result register.
// Holds head, node and free-stack memories; uses chm_pkg and chm_hash.
module chm_back
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int BCW = $clog2(MAX_BUCKETS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  item_t               q_item,
    input  logic                q_valid,
    output logic                q_take,
    output logic                hold,
    input  logic [MULT_W-1:0]   hash_mult,
    input  logic [MULT_W-1:0]   hash_add,
    input  logic [KEY_W-1:0]    hash_prime,
    input  logic [LIMIT_W-1:0]  long_lim,
    input  logic [LIMIT_W-1:0]  short_lim,
    input  logic                cfg_rb,
    input  logic [BCW-1:0]      cfg_n,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                found,
    output logic [KEY_W-1:0]    value_out,
    output logic [ECNT_W-1:0]   entry_count,
    output logic [BTOT_W-1:0]   bucket_total
);

    localparam int BIW = $clog2(MAX_BUCKETS);
    localparam int NIW = $clog2(MAX_ENTRIES);
    localparam int NCW = $clog2(MAX_ENTRIES + 1);
    localparam logic [NCW-1:0] NIL  = NCW'(MAX_ENTRIES);
    localparam logic [BCW-1:0] MAXB = BCW'(MAX_BUCKETS);
    localparam logic [BCW-1:0] INIT_B =
        BCW'((RESET_INIT_BUCKETS > MAX_BUCKETS) ? MAX_BUCKETS : RESET_INIT_BUCKETS);

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_OHASH, S_OHEAD, S_OHEADW, S_OWALK, S_OCMP, S_OFREE,
        S_OINS, S_RCLR, S_RHEAD, S_RHEADW, S_RNODE, S_RKEY, S_RHASH, S_RNEW,
        S_RPUSH, S_EMIT
    } state_t;

    // memories
    logic [NCW-1:0] heads_mem [2*MAX_BUCKETS];
    logic [KEY_W-1:0] keys_mem [MAX_ENTRIES];
    logic [KEY_W-1:0] vals_mem [MAX_ENTRIES];
    logic [NCW-1:0] links_mem [MAX_ENTRIES];
    logic [NIW-1:0] free_mem [MAX_ENTRIES];

    logic [BIW:0]     hd_raddr, hd_waddr;
    logic             hd_we;
    logic [NCW-1:0]   hd_wdata, hd_q;
    logic [NIW-1:0]   nd_raddr;
    logic             key_we, val_we, lk_we, fr_we;
    logic [NIW-1:0]   kv_waddr, lk_waddr, fr_raddr, fr_waddr, fr_wdata;
    logic [NCW-1:0]   lk_wdata, links_q;
    logic [KEY_W-1:0] keys_q, vals_q;
    logic [NIW-1:0]   free_q;

    // control and payload registers
    state_t              state_reg;
    logic                sel_reg;
    logic [BCW-1:0]      buckets_reg;
    logic [NCW-1:0]      count_reg, top_reg, lw_reg;
    logic [BIW-1:0]      idx_reg, h_reg;
    logic                pend_reg;
    logic [BCW-1:0]      pend_n_reg, rb_n_reg;
    logic                rb_item_reg;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg, val_reg;
    logic [NCW-1:0]      cur_reg, prev_reg, head0_reg, num_reg, nxt_reg;
    logic [NIW-1:0]      new_reg;
    logic [STATUS_W-1:0] res_status_reg, status_reg;
    logic                res_found_reg, found_reg;
    logic [KEY_W-1:0]    res_vout_reg, vout_reg;
    logic [ECNT_W-1:0]   ecnt_reg;
    logic [BTOT_W-1:0]   btot_reg;
    logic                out_valid_reg;

    // hash interface
    logic             hs_start, hs_done;
    logic [KEY_W-1:0] hs_key;
    logic [BCW-1:0]   hs_len;
    logic [BIW-1:0]   hs_bucket;

    // helpers
    logic [NCW-1:0] pos, cnt_dec, cnt_inc, num_inc;
    logic           fresh, key_hit, grow, shrink, take;
    logic           last_old, last_clr, last_init;
    logic [BCW-1:0] half_n, dbl_n, item_n;
    logic [BCW:0]   dbl;

    chm_hash #(
        .MAX_BUCKETS(MAX_BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hs_start),
        .key    (hs_key),
        .mult   (hash_mult),
        .add    (hash_add),
        .prime  (hash_prime),
        .len    (hs_len),
        .done   (hs_done),
        .bucket (hs_bucket)
    );

    always_comb
    begin
        pos       = top_reg - 1'b1;
        fresh     = (pos < lw_reg);
        key_hit   = (keys_q == key_reg);
        cnt_dec   = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
        cnt_inc   = count_reg + 1'b1;
        num_inc   = num_reg + 1'b1;
        half_n    = ((buckets_reg >> 1) == '0) ? buckets_reg : (buckets_reg >> 1);
        dbl       = {1'b0, buckets_reg} << 1;
        dbl_n     = (dbl > {1'b0, MAXB}) ? MAXB : dbl[BCW-1:0];
        item_n    = q_item.keep ? buckets_reg : (q_item.sat ? MAXB : BCW'(q_item.nbc));
        grow      = (32'(num_inc) > 32'(long_lim)) ||
                    ((32'(num_inc) > 32'(short_lim)) && (32'(cnt_inc) > 32'(dbl)));
        shrink    = (32'(cnt_dec) < 32'(buckets_reg));
        last_old  = (idx_reg == BIW'(buckets_reg - 1'b1));
        last_clr  = (idx_reg == BIW'(rb_n_reg - 1'b1));
        last_init = (idx_reg == BIW'(MAX_BUCKETS - 1));
        take      = (state_reg == S_IDLE) && !pend_reg && q_valid;
    end

    assign q_take = take;
    assign hold   = (state_reg == S_INIT);

    // memory port control
    always_comb
    begin
        hd_raddr = {sel_reg, idx_reg};
        hd_we    = 1'b0;
        hd_waddr = {sel_reg, h_reg};
        hd_wdata = NIL;
        nd_raddr = cur_reg[NIW-1:0];
        key_we   = 1'b0;
        val_we   = 1'b0;
        kv_waddr = cur_reg[NIW-1:0];
        lk_we    = 1'b0;
        lk_waddr = cur_reg[NIW-1:0];
        lk_wdata = hd_q;
        fr_raddr = pos[NIW-1:0];
        fr_we    = 1'b0;
        fr_waddr = top_reg[NIW-1:0];
        fr_wdata = cur_reg[NIW-1:0];
        hs_start = 1'b0;
        hs_key   = q_item.key;
        hs_len   = buckets_reg;
        case (state_reg)
            S_INIT:
            begin
                hd_we    = 1'b1;
                hd_waddr = {1'b0, idx_reg};
            end
            S_IDLE:
            begin
                hs_start = take && (q_item.op != OP_REBUILD);
            end
            S_OHEAD:
            begin
                hd_raddr = {sel_reg, h_reg};
            end
            S_OCMP:
            begin
                if (key_hit)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        val_we = 1'b1;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        if (prev_reg == NIL)
                        begin
                            hd_we    = 1'b1;
                            hd_wdata = links_q;
                        end
                        else
                        begin
                            lk_we    = 1'b1;
                            lk_waddr = prev_reg[NIW-1:0];
                            lk_wdata = links_q;
                        end
                        fr_we = (32'(top_reg) < MAX_ENTRIES);
                    end
                end
            end
            S_OINS:
            begin
                key_we   = 1'b1;
                val_we   = 1'b1;
                kv_waddr = new_reg;
                lk_we    = 1'b1;
                lk_waddr = new_reg;
                lk_wdata = head0_reg;
                hd_we    = 1'b1;
                hd_wdata = NCW'(new_reg);
            end
            S_RCLR:
            begin
                hd_we    = 1'b1;
                hd_waddr = {~sel_reg, idx_reg};
            end
            S_RHEAD:
            begin
                hd_raddr = {sel_reg, idx_reg};
            end
            S_RKEY:
            begin
                hs_start = 1'b1;
                hs_key   = keys_q;
                hs_len   = rb_n_reg;
            end
            S_RNEW:
            begin
                hd_raddr = {~sel_reg, h_reg};
            end
            S_RPUSH:
            begin
                lk_we    = 1'b1;
                lk_wdata = hd_q;
                hd_we    = 1'b1;
                hd_waddr = {~sel_reg, h_reg};
                hd_wdata = cur_reg;
            end
            default:
            begin
                hs_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            heads_mem[hd_waddr] <= hd_wdata;
        end
        hd_q <= heads_mem[hd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            keys_mem[kv_waddr] <= key_reg;
        end
        keys_q <= keys_mem[nd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            vals_mem[kv_waddr] <= val_reg;
        end
        vals_q <= vals_mem[nd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            links_mem[lk_waddr] <= lk_wdata;
        end
        links_q <= links_mem[nd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            free_mem[fr_waddr] <= fr_wdata;
        end
        free_q <= free_mem[fr_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            sel_reg        <= 1'b0;
            buckets_reg    <= INIT_B;
            count_reg      <= '0;
            top_reg        <= NIL;
            lw_reg         <= NIL;
            idx_reg        <= '0;
            h_reg          <= '0;
            pend_reg       <= 1'b0;
            pend_n_reg     <= '0;
            rb_n_reg       <= '0;
            rb_item_reg    <= 1'b0;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            val_reg        <= '0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            head0_reg      <= '0;
            num_reg        <= '0;
            nxt_reg        <= '0;
            new_reg        <= '0;
            res_status_reg <= '0;
            res_found_reg  <= 1'b0;
            res_vout_reg   <= '0;
            status_reg     <= '0;
            found_reg      <= 1'b0;
            vout_reg       <= '0;
            ecnt_reg       <= '0;
            btot_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_rb)
            begin
                pend_reg   <= 1'b1;
                pend_n_reg <= cfg_n;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (last_init)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pend_reg)
                    begin
                        pend_reg    <= cfg_rb;
                        rb_n_reg    <= pend_n_reg;
                        rb_item_reg <= 1'b0;
                        idx_reg     <= '0;
                        state_reg   <= S_RCLR;
                    end
                    else if (q_valid)
                    begin
                        op_reg         <= q_item.op;
                        key_reg        <= q_item.key;
                        val_reg        <= q_item.value;
                        res_status_reg <= ST_INSERTED;
                        res_found_reg  <= 1'b0;
                        res_vout_reg   <= '0;
                        if (q_item.op == OP_REBUILD)
                        begin
                            rb_n_reg    <= item_n;
                            rb_item_reg <= 1'b1;
                            idx_reg     <= '0;
                            state_reg   <= S_RCLR;
                        end
                        else
                        begin
                            state_reg <= S_OHASH;
                        end
                    end
                end
                S_OHASH:
                begin
                    if (hs_done)
                    begin
                        h_reg     <= hs_bucket;
                        state_reg <= S_OHEAD;
                    end
                end
                S_OHEAD:
                begin
                    state_reg <= S_OHEADW;
                end
                S_OHEADW:
                begin
                    cur_reg   <= hd_q;
                    head0_reg <= hd_q;
                    prev_reg  <= NIL;
                    num_reg   <= '0;
                    state_reg <= S_OWALK;
                end
                S_OWALK:
                begin
                    if (cur_reg != NIL)
                    begin
                        state_reg <= S_OCMP;
                    end
                    else if (op_reg != OP_INSERT)
                    begin
                        res_status_reg <= ST_MISSING;
                        state_reg      <= S_EMIT;
                    end
                    else if (top_reg == '0)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        top_reg <= pos;
                        if (fresh)
                        begin
                            new_reg   <= pos[NIW-1:0];
                            lw_reg    <= pos;
                            state_reg <= S_OINS;
                        end
                        else
                        begin
                            state_reg <= S_OFREE;
                        end
                    end
                end
                S_OCMP:
                begin
                    if (!key_hit)
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= links_q;
                        num_reg   <= num_inc;
                        state_reg <= S_OWALK;
                    end
                    else
                    begin
                        res_found_reg <= 1'b1;
                        res_vout_reg  <= vals_q;
                        state_reg     <= S_EMIT;
                        if (op_reg == OP_INSERT)
                        begin
                            res_status_reg <= ST_REPLACED;
                        end
                        else
                        begin
                            res_status_reg <= ST_FOUND;
                        end
                        if (op_reg == OP_REMOVE)
                        begin
                            if (32'(top_reg) < MAX_ENTRIES)
                            begin
                                top_reg <= top_reg + 1'b1;
                            end
                            count_reg <= cnt_dec;
                            if (shrink)
                            begin
                                rb_n_reg    <= half_n;
                                rb_item_reg <= 1'b1;
                                idx_reg     <= '0;
                                state_reg   <= S_RCLR;
                            end
                        end
                    end
                end
                S_OFREE:
                begin
                    new_reg   <= free_q;
                    state_reg <= S_OINS;
                end
                S_OINS:
                begin
                    count_reg      <= cnt_inc;
                    res_status_reg <= ST_INSERTED;
                    state_reg      <= S_EMIT;
                    if (grow)
                    begin
                        rb_n_reg    <= dbl_n;
                        rb_item_reg <= 1'b1;
                        idx_reg     <= '0;
                        state_reg   <= S_RCLR;
                    end
                end
                S_RCLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (last_clr)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_RHEAD;
                    end
                end
                S_RHEAD:
                begin
                    state_reg <= S_RHEADW;
                end
                S_RHEADW:
                begin
                    cur_reg   <= hd_q;
                    state_reg <= S_RNODE;
                end
                S_RNODE:
                begin
                    if (cur_reg != NIL)
                    begin
                        state_reg <= S_RKEY;
                    end
                    else if (!last_old)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RHEAD;
                    end
                    else
                    begin
                        idx_reg     <= '0;
                        sel_reg     <= ~sel_reg;
                        buckets_reg <= rb_n_reg;
                        state_reg   <= rb_item_reg ? S_EMIT : S_IDLE;
                    end
                end
                S_RKEY:
                begin
                    nxt_reg   <= links_q;
                    state_reg <= S_RHASH;
                end
                S_RHASH:
                begin
                    if (hs_done)
                    begin
                        h_reg     <= hs_bucket;
                        state_reg <= S_RNEW;
                    end
                end
                S_RNEW:
                begin
                    state_reg <= S_RPUSH;
                end
                S_RPUSH:
                begin
                    cur_reg   <= nxt_reg;
                    state_reg <= S_RNODE;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        status_reg    <= res_status_reg;
                        found_reg     <= res_found_reg;
                        vout_reg      <= res_vout_reg;
                        ecnt_reg      <= ECNT_W'(count_reg);
                        btot_reg      <= BTOT_W'(buckets_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign value_out    = vout_reg;
    assign entry_count  = ecnt_reg;
    assign bucket_total = btot_reg;

endmodule

// File: design/chained_hash_map_with_rehash_unit.sv
// Top level of the chained hash map: configuration registers, front end
// and back end. Uses chm_pkg, chm_front and chm_back.
//
// Key-to-value map with separate chaining over a pool of MAX_ENTRIES nodes.
// One item is handled at a time. Every get, insert or remove runs the hash
// (two 32x32 multiplies, then one or two 64-step remainder passes in one
// shared divider, the mod-p pass being skipped when the prime is zero),
// then walks the chain node by node and does its bookkeeping. A rebuild
// (explicit, on growth, on shrink or on a write of initial_buckets) clears
// every new bucket head, walks every old bucket and runs a full hash for
// each stored entry. After reset all MAX_BUCKETS bucket heads are cleared,
// during which in_stall is high; configuration writes are taken during
// that time.
module chained_hash_map_with_rehash_unit
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FUNC_W-1:0]    func,
    input  logic [KEY_W-1:0]     key,
    input  logic [KEY_W-1:0]     value,
    input  logic [NBC_W-1:0]     new_bucket_count,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic                 found,
    output logic [KEY_W-1:0]     value_out,
    output logic [ECNT_W-1:0]    entry_count,
    output logic [BTOT_W-1:0]    bucket_total
);

    localparam int BCW = $clog2(MAX_BUCKETS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MULT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 3'd5;

    logic [MULT_W-1:0]  mult_reg;
    logic [MULT_W-1:0]  add_reg;
    logic [KEY_W-1:0]   prime_reg;
    logic [LIMIT_W-1:0] long_reg;
    logic [LIMIT_W-1:0] short_reg;

    logic [NBC_W-1:0] init_raw;
    logic [BCW-1:0]   cfg_n;
    logic             cfg_rb;
    item_t            q_item;
    logic             q_valid;
    logic             q_take;
    logic             hold;

    always_comb
    begin
        init_raw = cfg_data[NBC_W-1:0];
        if (init_raw == '0)
        begin
            cfg_n = BCW'(1);
        end
        else if (32'(init_raw) > MAX_BUCKETS)
        begin
            cfg_n = BCW'(MAX_BUCKETS);
        end
        else
        begin
            cfg_n = BCW'(init_raw);
        end
        cfg_rb = cfg_we && (cfg_index == CFG_INIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg  <= 32'd1;
            add_reg   <= 32'd0;
            prime_reg <= 64'd32212254719;
            long_reg  <= 8'd10;
            short_reg <= 8'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MULT:  mult_reg  <= cfg_data[MULT_W-1:0];
                CFG_ADD:   add_reg   <= cfg_data[MULT_W-1:0];
                CFG_PRIME: prime_reg <= cfg_data;
                CFG_LONG:  long_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_SHORT: short_reg <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                    mult_reg <= mult_reg;
                end
            endcase
        end
    end

    chm_front #(
        .MAX_BUCKETS(MAX_BUCKETS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .key              (key),
        .value            (value),
        .new_bucket_count (new_bucket_count),
        .hold             (hold),
        .q_item           (q_item),
        .q_valid          (q_valid),
        .q_take           (q_take)
    );

    chm_back #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .hold         (hold),
        .hash_mult    (mult_reg),
        .hash_add     (add_reg),
        .hash_prime   (prime_reg),
        .long_lim     (long_reg),
        .short_lim    (short_reg),
        .cfg_rb       (cfg_rb),
        .cfg_n        (cfg_n),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found        (found),
        .value_out    (value_out),
        .entry_count  (entry_count),
        .bucket_total (bucket_total)
    );

endmodule

// File: test/tb_chained_hash_map_with_rehash_unit.sv
// Testbench for chained_hash_map_with_rehash_unit: a queue-fed driver, a monitor and a
// built-in model of the chained map that predicts every result beat in order.
// Depends on chm_pkg and the design top level only.
module tb_chained_hash_map_with_rehash_unit;
    import chm_pkg::*;

    localparam int NB = 1024;
    localparam int NE = 4096;
    localparam int NIL = NE;
    localparam int WATCH_LIMIT = 200000;

    typedef struct {
        op_t                op;
        logic [KEY_W-1:0]   k;
        logic [KEY_W-1:0]   v;
        logic [NBC_W-1:0]   nbc;
    } req_t;

    typedef struct {
        logic [STATUS_W-1:0] st;
        logic                fnd;
        logic [KEY_W-1:0]    vo;
        logic [ECNT_W-1:0]   cnt;
        logic [BTOT_W-1:0]   tot;
    } rsp_t;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] R_MULT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] R_ADD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] R_PRIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] R_LONG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] R_SHORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] R_INIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] R_NONE  = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic in_valid;
    logic in_stall;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
    logic [NBC_W-1:0] new_bucket_count;
    logic out_valid;
    logic out_stall;
    logic [STATUS_W-1:0] status;
    logic found;
    logic [KEY_W-1:0] value_out;
    logic [ECNT_W-1:0] entry_count;
    logic [BTOT_W-1:0] bucket_total;

    chained_hash_map_with_rehash_unit dut (.*);

    always #5 clk = ~clk;

    // model state
    logic [63:0] m_mult, m_add, m_prime;
    int unsigned m_long, m_short;
    int unsigned heads[NB];
    int unsigned scratch[NB];
    logic [63:0] nkey[NE];
    logic [63:0] nval[NE];
    int unsigned nlink[NE];
    int unsigned freelist[NE];
    int unsigned free_top, n_stored, n_buckets;

    req_t pending[$];
    rsp_t awaited[$];
    req_t held;
    int send_idle = 0, recv_idle = 0;
    int errors = 0, beats_in = 0, beats_out = 0, idle_cycles = 0;
    logic [63:0] keyset[64];

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int unsigned slot_of(logic [63:0] k, int unsigned len);
        logic [63:0] h;
        h = m_mult * k + m_add;
        if (m_prime != 0)
            h = h % m_prime;
        if (len == 0)
            len = 1;
        return int'(h % 64'(len));
    endfunction

    function automatic void rehash_to(int unsigned n);
        int unsigned e, h;
        if (n == 0)
            n = n_buckets;
        if (n > NB)
            n = NB;
        if (n == 0)
            n = 1;
        for (int i = 0; i < n; i++)
            scratch[i] = NIL;
        for (int i = 0; i < n_buckets; i++) begin
            while (heads[i] < NE) begin
                e = heads[i];
                h = slot_of(nkey[e], n);
                heads[i] = nlink[e];
                nlink[e] = scratch[h];
                scratch[h] = e;
            end
        end
        for (int i = 0; i < NB; i++)
            heads[i] = (i < n) ? scratch[i] : NIL;
        n_buckets = n;
    endfunction

    function automatic void map_reset();
        m_mult = 1;
        m_add = 0;
        m_prime = 64'd32212254719;
        m_long = 10;
        m_short = 5;
        for (int i = 0; i < NB; i++)
            heads[i] = NIL;
        for (int i = 0; i < NE; i++)
            freelist[i] = i;
        free_top = NE;
        n_stored = 0;
        n_buckets = RESET_INIT_BUCKETS;
    endfunction

    function automatic void map_config(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
        int unsigned b;
        case (idx)
            R_MULT:  m_mult = {32'd0, d[31:0]};
            R_ADD:   m_add = {32'd0, d[31:0]};
            R_PRIME: m_prime = d;
            R_LONG:  m_long = d[7:0];
            R_SHORT: m_short = d[7:0];
            R_INIT: begin
                b = d[10:0];
                if (b == 0)
                    b = 1;
                if (b > NB)
                    b = NB;
                rehash_to(b);
            end
            default: ;
        endcase
    endfunction

    function automatic rsp_t map_step(req_t r);
        rsp_t o;
        int unsigned h, cur, prev, num, e;
        o.st = ST_INSERTED;
        o.fnd = 0;
        o.vo = 0;
        if (r.op == OP_REBUILD) begin
            rehash_to(r.nbc);
        end else begin
            h = slot_of(r.k, n_buckets);
            cur = heads[h];
            prev = NIL;
            num = 0;
            while (cur < NE && nkey[cur] != r.k) begin
                prev = cur;
                cur = nlink[cur];
                num++;
            end
            if (r.op == OP_INSERT) begin
                if (cur != NIL) begin
                    o.fnd = 1;
                    o.st = ST_REPLACED;
                    o.vo = nval[cur];
                    nval[cur] = r.v;
                end else if (free_top == 0) begin
                    o.st = ST_FULL;
                end else begin
                    free_top--;
                    e = freelist[free_top];
                    nkey[e] = r.k;
                    nval[e] = r.v;
                    nlink[e] = heads[h];
                    heads[h] = e;
                    n_stored++;
                    num++;
                    if (num > m_long || (num > m_short && n_stored > 2 * n_buckets))
                        rehash_to(n_buckets * 2);
                end
            end else if (cur == NIL) begin
                o.st = ST_MISS;
            end else begin
                o.fnd = 1;
                o.st = ST_HIT;
                o.vo = nval[cur];
                if (r.op == OP_REMOVE) begin
                    if (prev == NIL)
                        heads[h] = nlink[cur];
                    else
                        nlink[prev] = nlink[cur];
                    freelist[free_top] = cur;
                    free_top++;
                    n_stored--;
                    if (n_stored < n_buckets)
                        rehash_to(n_buckets / 2);
                end
            end
        end
        o.cnt = ECNT_W'(n_stored);
        o.tot = BTOT_W'(n_buckets);
        return o;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            func <= OP_INSERT;
            key <= '0;
            value <= '0;
            new_bucket_count <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                awaited.push_back(map_step(held));
                beats_in++;
            end
            if (!in_valid || !in_stall) begin
                if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                    held = pending.pop_front();
                    in_valid <= 1'b1;
                    func <= held.op;
                    key <= held.k;
                    value <= held.v;
                    new_bucket_count <= held.nbc;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                beats_out++;
                if (awaited.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    rsp_t x;
                    x = awaited.pop_front();
                    if (status !== x.st)
                        report($sformatf("status %0d exp %0d", status, x.st));
                    if (found !== x.fnd)
                        report($sformatf("found %0b exp %0b", found, x.fnd));
                    if (value_out !== x.vo)
                        report($sformatf("value_out %h exp %h", value_out, x.vo));
                    if (entry_count !== x.cnt)
                        report($sformatf("entry_count %0d exp %0d", entry_count, x.cnt));
                    if (bucket_total !== x.tot)
                        report($sformatf("bucket_total %0d exp %0d", bucket_total, x.tot));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT) begin
            $display("[chained_hash_map_with_rehash_unit] ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        map_config(idx, d);
    endtask

    task automatic cfg_done();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() > 0 || awaited.size() > 0 || in_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add(input op_t op, input logic [63:0] k, input logic [63:0] v,
                       input logic [NBC_W-1:0] n);
        req_t r;
        r.op = op;
        r.k = k;
        r.v = v;
        r.nbc = n;
        pending.push_back(r);
    endtask

    task automatic random_items(input int n);
        int sel;
        logic [63:0] k;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            k = ($urandom_range(15) == 0) ? {$urandom, $urandom} : keyset[$urandom_range(63)];
            if (sel < 45)
                add(OP_INSERT, k, {$urandom, $urandom}, 11'($urandom));
            else if (sel < 70)
                add(OP_GET, k, {$urandom, $urandom}, 11'($urandom));
            else if (sel < 95)
                add(OP_REMOVE, k, {$urandom, $urandom}, 11'($urandom));
            else
                add(OP_REBUILD, k, {$urandom, $urandom},
                    ($urandom_range(3) == 0) ? 11'($urandom) : 11'($urandom_range(64)));
        end
    endtask

    initial begin
        map_reset();
        for (int i = 0; i < 64; i++)
            keyset[i] = {$urandom, $urandom};
        keyset[0] = '0;
        keyset[1] = '1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults after reset
        add(OP_GET, 64'd0, 64'd0, 11'd0);
        add(OP_REMOVE, '1, 64'd0, 11'd0);
        add(OP_INSERT, 64'd0, '1, 11'd0);
        add(OP_INSERT, '1, 64'd0, '1);
        add(OP_INSERT, 64'd0, 64'h5a5a_a5a5_0f0f_f0f0, 11'd0);
        add(OP_GET, 64'd0, 64'd0, 11'd0);
        add(OP_GET, '1, 64'd0, 11'd0);
        add(OP_REBUILD, 64'd0, 64'd0, 11'd0);
        add(OP_REBUILD, 64'd0, 64'd0, 11'd2047);
        add(OP_REBUILD, 64'd0, 64'd0, 11'd1);
        add(OP_REBUILD, 64'd0, 64'd0, 11'd1024);
        for (int i = 2; i < 10; i++)
            add(OP_INSERT, keyset[i], {$urandom, $urandom}, 11'd0);
        add(OP_REMOVE, 64'd0, 64'd0, 11'd0);
        add(OP_REMOVE, keyset[5], 64'd0, 11'd0);
        add(OP_REMOVE, keyset[5], 64'd0, 11'd0);
        add(OP_GET, keyset[3], 64'd0, 11'd0);
        drain();

        // hash changes with live entries, tiny chain limits, one bucket
        send_idle = 10;
        recv_idle = 47;
        cfg_write(R_MULT, {$urandom, $urandom});
        cfg_write(R_ADD, {$urandom, $urandom});
        cfg_write(R_PRIME, {$urandom, $urandom});
        cfg_write(R_LONG, 64'd1);
        cfg_write(R_SHORT, 64'd1);
        cfg_write(R_INIT, 64'd0);
        cfg_write(R_NONE, '1);
        cfg_done();
        random_items(500);
        drain();

        // extremes, no mod-p step
        send_idle = 47;
        recv_idle = 10;
        cfg_write(R_MULT, 64'hffff_ffff);
        cfg_write(R_ADD, 64'hffff_ffff);
        cfg_write(R_PRIME, 64'd0);
        cfg_write(R_LONG, 64'd255);
        cfg_write(R_SHORT, 64'd255);
        cfg_write(R_INIT, 64'd2047);
        cfg_done();
        random_items(500);
        drain();

        send_idle = 0;
        recv_idle = 0;
        cfg_write(R_MULT, {32'd0, $urandom} | 64'd1);
        cfg_write(R_ADD, {32'd0, $urandom});
        cfg_write(R_PRIME, '1);
        cfg_write(R_LONG, 64'd4);
        cfg_write(R_SHORT, 64'd2);
        cfg_write(R_INIT, 64'd3);
        cfg_done();
        random_items(600);
        drain();

        $display("covered %0d input beats and %0d result beats over four register settings,",
                 beats_in, beats_out);
        $display("including rebuilds, growth, shrink, hash changes and a full-width modulus");
        if (errors == 0 && awaited.size() == 0)
            $display("[chained_hash_map_with_rehash_unit] OK");
        else
            $display("[chained_hash_map_with_rehash_unit] ERROR");
        $finish;
    end

endmodule
